[rtl/core/tzpi_pkg.sv]
// ----------------------------------------------------------------------------
// tzpi_pkg: shared types and constants
// Item format between the classifier and the PI datapath, constants of the
// regulator, register indexes and reset values.
// ----------------------------------------------------------------------------
package tzpi_pkg;

    localparam int GAIN_ZONES  = 3;
    localparam int ZONE_W      = 2;
    localparam int RAW_W       = 12;
    localparam int TEMP_W      = 11;
    localparam int TIME_W      = 32;
    localparam int GAIN_W      = 8;
    localparam int PERIOD_W    = 10;
    localparam int ERR_W       = 12;
    localparam int INTEG_W     = 32;
    localparam int DUTY_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int QUEUE_DEPTH = 2;

    // setpoint = SET_BASE + raw * SET_SPAN / 2^SET_SHIFT
    localparam int SET_BASE  = 16;
    localparam int SET_SPAN  = 14;
    localparam int SET_SHIFT = 12;

    // drive limits: SAT_LIMIT and DEADBAND_LIM apply to the sum before the divide by ten
    localparam int DRIVE_MAX    = 255;
    localparam int SAT_LIMIT    = 2560;
    localparam int DEADBAND_LIM = 500;
    localparam int RECIP_10     = 6554;
    localparam int RECIP_SHIFT  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_P_GAIN_0    = 3'd0,
        CFG_I_GAIN_0    = 3'd1,
        CFG_P_GAIN_1    = 3'd2,
        CFG_I_GAIN_1    = 3'd3,
        CFG_P_GAIN_2    = 3'd4,
        CFG_I_GAIN_2    = 3'd5,
        CFG_SAMPLE_PER  = 3'd6
    } cfg_index_t;

    localparam logic [GAIN_W-1:0]   RST_P_GAIN_0 = 8'd7;
    localparam logic [GAIN_W-1:0]   RST_I_GAIN_0 = 8'd3;
    localparam logic [GAIN_W-1:0]   RST_P_GAIN_1 = 8'd2;
    localparam logic [GAIN_W-1:0]   RST_I_GAIN_1 = 8'd2;
    localparam logic [GAIN_W-1:0]   RST_P_GAIN_2 = 8'd10;
    localparam logic [GAIN_W-1:0]   RST_I_GAIN_2 = 8'd10;
    localparam logic [PERIOD_W-1:0] RST_PERIOD   = 10'd1;

    typedef struct packed {
        logic [ZONE_W-1:0]       zone;
        logic signed [ERR_W-1:0] err;
        logic                    sampled;
    } tzpi_item_t;

endpackage

[rtl/core/three_zone_pi_heat_cool.sv]
// ----------------------------------------------------------------------------
// three_zone_pi_heat_cool: three-zone PI heat/cool regulator
// Fixed-point PI control with shared sample timer, saturating integrators,
// drive clamp and deadband, split into heater and cooler duty.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  input     in_valid / in_ready        zone, setpoint_raw, temperature, now_ms
//  result    out_valid / out_ready      heat_duty, cool_duty, sampled
//  config    cfg_wr_en                  cfg_index, cfg_data
//
//  The classifier takes an item whenever the queue has room. The PI
//  datapath steps a sampled item through pop, weight multiply, integrator
//  add, gain multiplies, sum and clamp, divide and output, and others
//  through pop and output; it pops no new item until the last leaves
//  output, which sets the sustained rate. Reset clears the integrators
//  and the last sample time and loads the default gains. A stalled
//  output holds the datapath; the queue absorbs up to two further items.
// ----------------------------------------------------------------------------
module three_zone_pi_heat_cool
    import tzpi_pkg::*;
#(
    parameter int ZONES = 3
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ZONE_W-1:0]        zone,
    input  logic [RAW_W-1:0]         setpoint_raw,
    input  logic signed [TEMP_W-1:0] temperature,
    input  logic [TIME_W-1:0]        now_ms,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [DUTY_W-1:0]        heat_duty,
    output logic [DUTY_W-1:0]        cool_duty,
    output logic                     sampled,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    logic [GAIN_ZONES-1:0][GAIN_W-1:0] p_gain_reg;
    logic [GAIN_ZONES-1:0][GAIN_W-1:0] i_gain_reg;
    logic [PERIOD_W-1:0]               period_reg;

    logic       push;
    tzpi_item_t push_item;
    logic       q_full;
    logic       q_valid;
    logic       pop;
    tzpi_item_t pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_gain_reg[0] <= RST_P_GAIN_0;
            i_gain_reg[0] <= RST_I_GAIN_0;
            p_gain_reg[1] <= RST_P_GAIN_1;
            i_gain_reg[1] <= RST_I_GAIN_1;
            p_gain_reg[2] <= RST_P_GAIN_2;
            i_gain_reg[2] <= RST_I_GAIN_2;
            period_reg    <= RST_PERIOD;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_P_GAIN_0:   p_gain_reg[0] <= cfg_data[GAIN_W-1:0];
                CFG_I_GAIN_0:   i_gain_reg[0] <= cfg_data[GAIN_W-1:0];
                CFG_P_GAIN_1:   p_gain_reg[1] <= cfg_data[GAIN_W-1:0];
                CFG_I_GAIN_1:   i_gain_reg[1] <= cfg_data[GAIN_W-1:0];
                CFG_P_GAIN_2:   p_gain_reg[2] <= cfg_data[GAIN_W-1:0];
                CFG_I_GAIN_2:   i_gain_reg[2] <= cfg_data[GAIN_W-1:0];
                CFG_SAMPLE_PER: period_reg    <= cfg_data[PERIOD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    tzpi_front #(
        .ZONES (ZONES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .zone          (zone),
        .setpoint_raw  (setpoint_raw),
        .temperature   (temperature),
        .now_ms        (now_ms),
        .sample_period (period_reg),
        .push          (push),
        .push_item     (push_item),
        .q_full        (q_full)
    );

    tzpi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .pop       (pop),
        .pop_item  (pop_item)
    );

    tzpi_back #(
        .ZONES (ZONES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .pop           (pop),
        .pop_item      (pop_item),
        .p_gain        (p_gain_reg),
        .i_gain        (i_gain_reg),
        .sample_period (period_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .heat_duty     (heat_duty),
        .cool_duty     (cool_duty),
        .sampled       (sampled)
    );

endmodule

[rtl/core/tzpi_front.sv]
// ----------------------------------------------------------------------------
// tzpi_front: item classifier
// Checks zone and elapsed time, owns the last sample time, forms the error.
// ----------------------------------------------------------------------------
module tzpi_front
    import tzpi_pkg::*;
#(
    parameter int ZONES = 3
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ZONE_W-1:0]        zone,
    input  logic [RAW_W-1:0]         setpoint_raw,
    input  logic signed [TEMP_W-1:0] temperature,
    input  logic [TIME_W-1:0]        now_ms,
    input  logic [PERIOD_W-1:0]      sample_period,
    output logic                     push,
    output tzpi_item_t               push_item,
    input  logic                     q_full
);

    logic [TIME_W-1:0]   last_ms_reg;
    logic [TIME_W-1:0]   diff;
    logic                zone_ok;
    logic                sample_ok;
    logic [RAW_W+3:0]    raw_scaled;
    logic [8:0]          ten_setp;
    logic signed [ERR_W-1:0] err;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    assign diff    = now_ms - last_ms_reg;
    assign zone_ok = ({30'd0, zone} < ZONES) && ({30'd0, zone} < GAIN_ZONES);
    assign sample_ok = zone_ok && !diff[TIME_W-1]
                       && (diff >= {{(TIME_W-PERIOD_W){1'b0}}, sample_period});

    assign raw_scaled = {4'd0, setpoint_raw} * 16'(SET_SPAN);
    assign ten_setp   = 9'd10 * (9'(SET_BASE) + {5'd0, raw_scaled[RAW_W+3:SET_SHIFT]});
    assign err        = $signed({3'd0, ten_setp})
                        - {{(ERR_W-TEMP_W){temperature[TEMP_W-1]}}, temperature};

    assign push_item.zone    = zone;
    assign push_item.err     = err;
    assign push_item.sampled = sample_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_ms_reg <= '0;
        end
        else if (push && sample_ok)
        begin
            last_ms_reg <= now_ms;
        end
    end

endmodule

[rtl/core/tzpi_queue.sv]
// ----------------------------------------------------------------------------
// tzpi_queue: small item FIFO
// Decouples the classifier from the PI datapath.
// ----------------------------------------------------------------------------
module tzpi_queue
    import tzpi_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  tzpi_item_t push_item,
    output logic       full,
    output logic       q_valid,
    input  logic       pop,
    output tzpi_item_t pop_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    tzpi_item_t        entry_reg [DEPTH];
    logic [AW-1:0]     wptr_reg;
    logic [AW-1:0]     rptr_reg;
    logic [AW:0]       count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign pop_item = entry_reg[rptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH-1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH-1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/core/tzpi_back.sv]
// ----------------------------------------------------------------------------
// tzpi_back: PI datapath
// Integrator update, gain products, clamp, deadband and divide by ten.
// ----------------------------------------------------------------------------
module tzpi_back
    import tzpi_pkg::*;
#(
    parameter int ZONES = 3
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_valid,
    output logic                                 pop,
    input  tzpi_item_t                           pop_item,
    input  logic [GAIN_ZONES-1:0][GAIN_W-1:0]    p_gain,
    input  logic [GAIN_ZONES-1:0][GAIN_W-1:0]    i_gain,
    input  logic [PERIOD_W-1:0]                  sample_period,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [DUTY_W-1:0]                    heat_duty,
    output logic [DUTY_W-1:0]                    cool_duty,
    output logic                                 sampled
);

    localparam int NZ = (ZONES < GAIN_ZONES) ? ZONES : GAIN_ZONES;
    localparam int ZW = (NZ > 1) ? $clog2(NZ) : 1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_WGT   = 7'b0000010,
        ST_INTEG = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_DRIVE = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } back_state_t;

    back_state_t                 state_reg;
    back_state_t                 state_next;
    tzpi_item_t                  item_reg;
    logic signed [INTEG_W-1:0]   integ_reg [NZ];
    logic signed [22:0]          ep_reg;
    logic signed [INTEG_W-1:0]   inew_reg;
    logic signed [20:0]          pe_reg;
    logic signed [40:0]          ie_reg;
    logic [11:0]                 mag_reg;
    logic                        neg_reg;
    logic                        sat_reg;
    logic [DUTY_W-1:0]           heat_res_reg;
    logic [DUTY_W-1:0]           cool_res_reg;
    logic                        out_valid_reg;
    logic [DUTY_W-1:0]           heat_out_reg;
    logic [DUTY_W-1:0]           cool_out_reg;
    logic                        sampled_out_reg;

    logic [ZW-1:0]               zidx;
    logic [1:0]                  gsel;
    logic signed [INTEG_W:0]     acc;
    logic signed [INTEG_W-1:0]   acc_sat;
    logic signed [41:0]          h;
    logic [41:0]                 h_abs;
    logic [24:0]                 quot;
    logic [DUTY_W-1:0]           drive;
    logic                        out_load;

    assign zidx = item_reg.zone[ZW-1:0];
    assign gsel = item_reg.zone;
    assign pop  = (state_reg == ST_IDLE);

    assign acc = {integ_reg[zidx][INTEG_W-1], integ_reg[zidx]}
                 + {{(INTEG_W-22){ep_reg[22]}}, ep_reg};

    always_comb
    begin
        if (acc[INTEG_W] != acc[INTEG_W-1])
        begin
            acc_sat = acc[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                   : {1'b0, {(INTEG_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc[INTEG_W-1:0];
        end
    end

    assign h     = {{21{pe_reg[20]}}, pe_reg} + {ie_reg[40], ie_reg};
    assign h_abs = h[41] ? -h : h;
    assign quot  = {13'd0, mag_reg} * 25'(RECIP_10);

    always_comb
    begin
        if (sat_reg)
        begin
            drive = DUTY_W'(DRIVE_MAX);
        end
        else if (mag_reg < 12'(DEADBAND_LIM))
        begin
            drive = '0;
        end
        else
        begin
            drive = quot[RECIP_SHIFT +: DUTY_W];
        end
    end

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = pop_item.sampled ? ST_WGT : ST_OUT;
                end
            end
            ST_WGT:   state_next = ST_INTEG;
            ST_INTEG: state_next = ST_MUL;
            ST_MUL:   state_next = ST_DRIVE;
            ST_DRIVE: state_next = ST_DIV;
            ST_DIV:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NZ; i++)
            begin
                integ_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_INTEG)
            begin
                integ_reg[zidx] <= acc_sat;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                item_reg     <= pop_item;
                heat_res_reg <= '0;
                cool_res_reg <= '0;
            end
            ST_WGT:
            begin
                ep_reg <= item_reg.err * $signed({1'b0, sample_period});
            end
            ST_INTEG:
            begin
                inew_reg <= acc_sat;
            end
            ST_MUL:
            begin
                pe_reg <= item_reg.err * $signed({1'b0, p_gain[gsel]});
                ie_reg <= inew_reg * $signed({1'b0, i_gain[gsel]});
            end
            ST_DRIVE:
            begin
                neg_reg <= h[41];
                sat_reg <= (h >= 42'(SAT_LIMIT)) || (h <= -42'(SAT_LIMIT));
                mag_reg <= h_abs[11:0];
            end
            ST_DIV:
            begin
                heat_res_reg <= neg_reg ? '0 : drive;
                cool_res_reg <= neg_reg ? drive : '0;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            heat_out_reg    <= heat_res_reg;
            cool_out_reg    <= cool_res_reg;
            sampled_out_reg <= item_reg.sampled;
        end
    end

    assign out_valid = out_valid_reg;
    assign heat_duty = heat_out_reg;
    assign cool_duty = cool_out_reg;
    assign sampled   = sampled_out_reg;

endmodule
